/* rtl/core/vtm_pkg.sv */
// Shared types and constants of the virtual timer multiplexer.
// No dependencies; imported by vtm_ctrl, vtm_datapath and the top level.
package vtm_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam int CMD_W  = 2;
	localparam int DUR_W  = 32;
	localparam int SID_W  = 4;
	localparam int STAT_W = 3;
	localparam int NUM_W  = 4;
	localparam int TIME_W = 32;

	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ONE    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REP    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd3;

	localparam logic [STAT_W-1:0] ST_STARTED   = 3'd0;
	localparam logic [STAT_W-1:0] ST_FIRED     = 3'd1;
	localparam logic [STAT_W-1:0] ST_CANCELLED = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STAT_W-1:0] ST_BAD_ID    = 3'd4;

	// controller -> datapath commands
	typedef struct packed {
		logic accept;
		logic start_step;
		logic cancel;
		logic scan_clr;
		logic scan_run;
		logic apply;
		logic flush;
	} vtm_ctl_t;

	// datapath -> controller status
	typedef struct packed {
		logic start_end;
		logic scan_done;
		logic found;
		logic cnt_last;
		logic pend_v;
		logic out_free;
	} vtm_sts_t;

endpackage

/* rtl/core/vtm_ctrl.sv */
// Sequencer of the virtual timer multiplexer: command phase, then scan/fire passes.
// Depends on vtm_pkg; drives vtm_datapath through vtm_ctl_t.
module vtm_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic [vtm_pkg::CMD_W-1:0] cmd,
	input  vtm_pkg::vtm_sts_t         st,
	output vtm_pkg::vtm_ctl_t         ctl
);
	import vtm_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_START  = 3'd1;
	localparam logic [2:0] S_CANCEL = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_APPLY  = 3'd4;
	localparam logic [2:0] S_FLUSH  = 3'd5;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.accept = 1'b1;
					case (cmd)
						CMD_TICK:         state_d = S_SCAN;
						CMD_ONE, CMD_REP: state_d = S_START;
						default:          state_d = S_CANCEL;
					endcase
				end
			end
			S_START: begin
				ctl.start_step = 1'b1;
				if (st.start_end) begin
					ctl.scan_clr = 1'b1;
					state_d      = S_SCAN;
				end
			end
			S_CANCEL: begin
				ctl.cancel   = 1'b1;
				ctl.scan_clr = 1'b1;
				state_d      = S_SCAN;
			end
			S_SCAN: begin
				ctl.scan_run = 1'b1;
				if (st.scan_done) begin
					state_d = st.found ? S_APPLY : S_FLUSH;
				end
			end
			S_APPLY: begin
				// the held result moves to the output word, so it must be free
				if (!st.pend_v || st.out_free) begin
					ctl.apply = 1'b1;
					if (st.cnt_last) begin
						state_d = S_FLUSH;
					end else begin
						ctl.scan_clr = 1'b1;
						state_d      = S_SCAN;
					end
				end
			end
			S_FLUSH: begin
				if (!st.pend_v) begin
					state_d = S_IDLE;
				end else if (st.out_free) begin
					ctl.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* rtl/core/vtm_datapath.sv */
// Datapath of the virtual timer multiplexer: tick counter, slot tables, oldest-due scan,
// held result and output word. Depends on vtm_pkg; sequenced by vtm_ctrl.
module vtm_datapath #(
	parameter int SLOTS = vtm_pkg::SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [vtm_pkg::CMD_W-1:0]   cmd,
	input  logic [vtm_pkg::DUR_W-1:0]   duration,
	input  logic [vtm_pkg::SID_W-1:0]   slot_id,
	input  vtm_pkg::vtm_ctl_t           ctl,
	output vtm_pkg::vtm_sts_t           st,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [vtm_pkg::STAT_W-1:0]  status,
	output logic [vtm_pkg::NUM_W-1:0]   timer_num,
	output logic [vtm_pkg::TIME_W-1:0]  time_stamp,
	output logic                        last
);
	import vtm_pkg::*;

	localparam int             IDX_W    = $clog2(SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	logic [TIME_W-1:0] now_q;
	logic              rep_q;
	logic [DUR_W-1:0]  dur_q;
	logic [SID_W-1:0]  sid_q;
	logic [SLOTS-1:0]  busy_q, done_q;
	logic [IDX_W-1:0]  idx_q;
	logic              issued_q;
	logic              v_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [TIME_W-1:0] exp_s1;
	logic [DUR_W-1:0]  per_s1;
	logic              found_q;
	logic [IDX_W-1:0]  best_q;
	logic [TIME_W-1:0] best_age_q;
	logic [DUR_W-1:0]  best_per_q;
	logic [CNT_W-1:0]  n_q;
	logic              pend_v_q;
	logic [STAT_W-1:0] pend_status_q;
	logic [NUM_W-1:0]  pend_num_q;
	logic              out_v_q;
	logic [STAT_W-1:0] out_status_q;
	logic [NUM_W-1:0]  out_num_q;
	logic [TIME_W-1:0] out_stamp_q;
	logic              out_last_q;

	logic [TIME_W-1:0] expiry_mem [SLOTS];
	logic [DUR_W-1:0]  period_mem [SLOTS];

	logic              free_here, at_last, cancel_ok, cand, out_free;
	logic [TIME_W-1:0] age;
	logic              emit;
	logic [STAT_W-1:0] e_status;
	logic [NUM_W-1:0]  e_num;
	logic              exp_we, per_we;
	logic [IDX_W-1:0]  exp_wa;
	logic [TIME_W-1:0] exp_wd;

	assign free_here = !busy_q[idx_q];
	assign at_last   = (idx_q == LAST_IDX);
	assign out_free  = !out_v_q || rsp_ready;

	always_comb begin
		cancel_ok = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (32'(sid_q) == i && busy_q[i]) begin
				cancel_ok = 1'b1;
			end
		end
	end

	// wrap-safe due test: due when now - expiry lies in the lower half range
	assign age  = now_q - exp_s1;
	assign cand = v_s1 && busy_q[idx_s1] && !done_q[idx_s1] && !age[TIME_W-1]
		&& (!found_q || age > best_age_q);

	always_comb begin
		emit     = 1'b0;
		e_status = ST_FIRED;
		e_num    = '0;
		if (ctl.start_step) begin
			if (free_here) begin
				emit     = 1'b1;
				e_status = ST_STARTED;
				e_num    = NUM_W'(idx_q);
			end else if (at_last) begin
				emit     = 1'b1;
				e_status = ST_FULL;
			end
		end
		if (ctl.cancel) begin
			emit     = 1'b1;
			e_status = cancel_ok ? ST_CANCELLED : ST_BAD_ID;
			e_num    = sid_q;
		end
		if (ctl.apply) begin
			emit     = 1'b1;
			e_status = ST_FIRED;
			e_num    = NUM_W'(best_q);
		end
	end

	assign per_we = ctl.start_step && free_here;
	assign exp_we = per_we || (ctl.apply && best_per_q != '0);
	assign exp_wa = ctl.apply ? best_q : idx_q;
	assign exp_wd = now_q + (ctl.apply ? best_per_q : dur_q);

	always_ff @(posedge clk) begin
		if (exp_we) begin
			expiry_mem[exp_wa] <= exp_wd;
		end
		if (per_we) begin
			period_mem[idx_q] <= rep_q ? dur_q : '0;
		end
		if (ctl.scan_run) begin
			exp_s1 <= expiry_mem[idx_q];
			per_s1 <= period_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q    <= '0;
			busy_q   <= '0;
			done_q   <= '0;
			idx_q    <= '0;
			issued_q <= 1'b0;
			v_s1     <= 1'b0;
			found_q  <= 1'b0;
			n_q      <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (ctl.accept) begin
				if (cmd == CMD_TICK) begin
					now_q <= now_q + 1'b1;
				end
				done_q <= '0;
				n_q    <= '0;
			end
			if (ctl.accept || ctl.scan_clr) begin
				idx_q    <= '0;
				issued_q <= 1'b0;
				v_s1     <= 1'b0;
				found_q  <= 1'b0;
			end
			if (ctl.start_step) begin
				if (free_here) begin
					busy_q[idx_q] <= 1'b1;
				end else if (!at_last) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (ctl.cancel && cancel_ok) begin
				busy_q[IDX_W'(sid_q)] <= 1'b0;
			end
			if (ctl.scan_run) begin
				v_s1 <= !issued_q;
				if (!issued_q) begin
					if (at_last) begin
						issued_q <= 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				if (cand) begin
					found_q <= 1'b1;
				end
			end
			if (ctl.apply) begin
				done_q[best_q] <= 1'b1;
				if (best_per_q == '0) begin
					busy_q[best_q] <= 1'b0;
				end
			end
			if (emit) begin
				n_q      <= n_q + 1'b1;
				pend_v_q <= 1'b1;
			end else if (ctl.flush) begin
				pend_v_q <= 1'b0;
			end
			if ((emit && pend_v_q) || ctl.flush) begin
				out_v_q <= 1'b1;
			end else if (rsp_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			rep_q <= (cmd == CMD_REP);
			dur_q <= duration;
			sid_q <= slot_id;
		end
		if (ctl.scan_run) begin
			idx_s1 <= idx_q;
		end
		if (ctl.scan_run && cand) begin
			best_q     <= idx_s1;
			best_age_q <= age;
			best_per_q <= per_s1;
		end
		if (emit) begin
			pend_status_q <= e_status;
			pend_num_q    <= e_num;
		end
		// a new result pushes the held one out as a non-final word; the stamp is
		// frozen with the word since a tick may be taken while it still waits
		if (emit && pend_v_q) begin
			out_status_q <= pend_status_q;
			out_num_q    <= pend_num_q;
			out_stamp_q  <= now_q;
			out_last_q   <= 1'b0;
		end else if (ctl.flush) begin
			out_status_q <= pend_status_q;
			out_num_q    <= pend_num_q;
			out_stamp_q  <= now_q;
			out_last_q   <= 1'b1;
		end
	end

	assign st.start_end = free_here || at_last;
	assign st.scan_done = v_s1 && (idx_s1 == LAST_IDX);
	assign st.found     = found_q || cand;
	assign st.cnt_last  = (n_q == CNT_W'(MAX_RESULTS - 1));
	assign st.pend_v    = pend_v_q;
	assign st.out_free  = out_free;

	assign rsp_valid  = out_v_q;
	assign status     = out_status_q;
	assign timer_num  = out_num_q;
	assign time_stamp = out_stamp_q;
	assign last       = out_last_q;

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && pend_v_q) |-> out_free)
		else $error("held result pushed onto a full output word");
	a_budget: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (n_q < CNT_W'(MAX_RESULTS)))
		else $error("result budget exceeded");
	a_fire_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.apply |-> (found_q && busy_q[best_q] && !done_q[best_q]))
		else $error("fired a slot that is free or already fired");
	a_accept_clean: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept |-> !pend_v_q)
		else $error("new command while a result is still held");

endmodule

/* rtl/core/virtual_timer_multiplexer.sv */
// Virtual timer multiplexer, top level: joins vtm_ctrl and vtm_datapath.
// Depends on vtm_pkg, vtm_ctrl, vtm_datapath.
//
// One command word at a time: tick, start one-shot, start repeated or cancel. A start or
// cancel answers with one result word, then every due timer fires, oldest first, ties to
// the lowest slot, at most 16 result words per command; the final word carries last.
// Work per command: an accept, a search for a free slot on a start (a cancel step on a
// cancel), then one scan pass plus an apply for each fired timer, a final pass that finds
// nothing due (skipped once the 16th word is made), and the release of the last word.
// The scan reads the single-port expiry and period tables one slot per cycle. An apply or
// the release of a held result waits while the output word is still held by the consumer.
// The output word, time stamp included, is registered, so a waiting result does not block
// the next command.
module virtual_timer_multiplexer #(
	parameter int SLOTS = vtm_pkg::SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [vtm_pkg::CMD_W-1:0]   cmd,
	input  logic [vtm_pkg::DUR_W-1:0]   duration,
	input  logic [vtm_pkg::SID_W-1:0]   slot_id,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [vtm_pkg::STAT_W-1:0]  status,
	output logic [vtm_pkg::NUM_W-1:0]   timer_num,
	output logic [vtm_pkg::TIME_W-1:0]  time_stamp,
	output logic                        last
);
	import vtm_pkg::*;

	vtm_ctl_t ctl;
	vtm_sts_t st;

	vtm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (cmd),
		.st        (st),
		.ctl       (ctl)
	);

	vtm_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.duration   (duration),
		.slot_id    (slot_id),
		.ctl        (ctl),
		.st         (st),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.timer_num  (timer_num),
		.time_stamp (time_stamp),
		.last       (last)
	);

endmodule

/* test/vtm_checker.sv */
// Checker for the virtual timer multiplexer: watches the command and result channels,
// keeps its own copy of the timer table and compares every result word in order.
// Depends on vtm_pkg only.
module vtm_checker
	import vtm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [DUR_W-1:0]  duration,
	input  logic [SID_W-1:0]  slot_id,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  logic [STAT_W-1:0] status,
	input  logic [NUM_W-1:0]  timer_num,
	input  logic [TIME_W-1:0] time_stamp,
	input  logic              last,
	output int                mismatches,
	output int                words_owed,
	output int                cmds_seen,
	output int                words_seen,
	output int                fires_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = SLOTS_DEF;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [NUM_W-1:0]  num;
		logic [TIME_W-1:0] stamp;
		logic              last;
	} timer_word_t;

	// shadow timer table
	logic [TIME_W-1:0] now_ticks;
	logic              busy [SLOTS];
	logic [TIME_W-1:0] expiry [SLOTS];
	logic [DUR_W-1:0]  period [SLOTS];

	timer_word_t owed_words [$];
	int err_total   = 0;
	int cmd_total   = 0;
	int word_total  = 0;
	int fire_total  = 0;
	int owed_count  = 0;

	assign mismatches = err_total;
	assign words_owed = owed_count;
	assign cmds_seen  = cmd_total;
	assign words_seen = word_total;
	assign fires_seen = fire_total;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		if (err_total < 100)
			$display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
		err_total++;
	endtask

	function automatic timer_word_t word_at(input logic [STAT_W-1:0] st,
			input logic [NUM_W-1:0] num);
		timer_word_t w;
		w.status = st;
		w.num    = num;
		w.stamp  = now_ticks;
		w.last   = 1'b0;
		return w;
	endfunction

	// Apply one command to the shadow table and queue the words it must produce.
	task automatic run_command(input logic [CMD_W-1:0] op, input logic [DUR_W-1:0] dur,
			input logic [SID_W-1:0] sid);
		timer_word_t made [$];
		logic done [SLOTS];
		logic placed;
		logic scanning;
		int pick;
		logic [TIME_W-1:0] age;
		logic [TIME_W-1:0] oldest;
		foreach (done[i]) done[i] = 1'b0;
		case (op)
		CMD_TICK: now_ticks = now_ticks + 1'b1;
		CMD_ONE, CMD_REP: begin
			placed = 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				if (!placed && !busy[i]) begin
					placed    = 1'b1;
					busy[i]   = 1'b1;
					expiry[i] = now_ticks + dur;
					period[i] = (op == CMD_REP) ? dur : '0;
					made.push_back(word_at(ST_STARTED, NUM_W'(i)));
				end
			end
			if (!placed)
				made.push_back(word_at(ST_FULL, '0));
		end
		default: begin
			if (int'(sid) < SLOTS && busy[sid]) begin
				busy[sid] = 1'b0;
				made.push_back(word_at(ST_CANCELLED, sid));
			end else begin
				made.push_back(word_at(ST_BAD_ID, sid));
			end
		end
		endcase

		// due timers, most overdue first, ties to the lowest slot, each once per command
		scanning = 1'b1;
		while (scanning && made.size() < MAX_RESULTS) begin
			pick   = -1;
			oldest = '0;
			for (int i = 0; i < SLOTS; i++) begin
				age = now_ticks - expiry[i];
				if (busy[i] && !done[i] && !age[TIME_W-1] && (pick < 0 || age > oldest)) begin
					pick   = i;
					oldest = age;
				end
			end
			if (pick < 0) begin
				scanning = 1'b0;
			end else begin
				done[pick] = 1'b1;
				made.push_back(word_at(ST_FIRED, NUM_W'(pick)));
				if (period[pick] != '0)
					expiry[pick] = now_ticks + period[pick];
				else
					busy[pick] = 1'b0;
			end
		end

		if (made.size() != 0)
			made[made.size()-1].last = 1'b1;
		foreach (made[k]) owed_words.push_back(made[k]);
	endtask

	always @(posedge clk) begin
		timer_word_t want;
		if (!arst_n) begin
			now_ticks = '0;
			foreach (busy[i]) busy[i] = 1'b0;
			owed_words.delete();
		end else begin
			// a word can never belong to the command taken at the same edge
			if (rsp_valid && rsp_ready) begin
				word_total++;
				if (owed_words.size() == 0) begin
					report("unowed word, status", 32'(status), '0);
				end else begin
					want = owed_words.pop_front();
					if (status !== want.status)
						report("status", 32'(status), 32'(want.status));
					if (timer_num !== want.num)
						report("timer_num", 32'(timer_num), 32'(want.num));
					if (time_stamp !== want.stamp)
						report("time_stamp", time_stamp, want.stamp);
					if (last !== want.last)
						report("last", 32'(last), 32'(want.last));
					if (want.status == ST_FIRED)
						fire_total++;
				end
			end
			if (req_valid && req_ready) begin
				cmd_total++;
				run_command(cmd, duration, slot_id);
			end
		end
		owed_count <= owed_words.size();
	end

endmodule

/* test/virtual_timer_multiplexer_tb.sv */
// Testbench top for the virtual timer multiplexer: clock, reset, command stimulus,
// result back-pressure, watchdog and verdict. Depends on vtm_pkg, vtm_checker and the RTL.
module virtual_timer_multiplexer_tb;
	import vtm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS   = 200;
	localparam int CALM_ITEMS     = 40;
	localparam int TAIL_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;

	logic              clk;
	logic              arst_n     = 1'b0;
	logic              req_valid  = 1'b0;
	logic              req_ready;
	logic [CMD_W-1:0]  cmd        = CMD_TICK;
	logic [DUR_W-1:0]  duration   = '0;
	logic [SID_W-1:0]  slot_id    = '0;
	logic              rsp_valid;
	logic              rsp_ready  = 1'b0;
	logic [STAT_W-1:0] status;
	logic [NUM_W-1:0]  timer_num;
	logic [TIME_W-1:0] time_stamp;
	logic              last;

	int mismatches;
	int words_owed;
	int cmds_seen;
	int words_seen;
	int fires_seen;

	logic calm      = 1'b0;
	int   issued    = 0;
	int   stall_left = 0;
	int   quiet     = 0;

	virtual_timer_multiplexer u_top (.*);

	vtm_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result back-pressure in bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_ready  <= (stall_left == 1);
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 7);
			rsp_ready  <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet <= 0;
		end else if (quiet == WATCHDOG_LIMIT) begin
			$display("no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("FAIL virtual_timer_multiplexer");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic issue(input logic [CMD_W-1:0] c, input logic [DUR_W-1:0] d,
			input logic [SID_W-1:0] s);
		if (!calm && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req_valid <= 1'b1;
		cmd       <= c;
		duration  <= d;
		slot_id   <= s;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		issued++;
	endtask

	// mostly short timers, with wrap-boundary and full-range values mixed in
	function automatic logic [DUR_W-1:0] pick_duration();
		case ($urandom_range(0, 9))
		0, 1, 2, 3, 4, 5: return DUR_W'($urandom_range(0, 12));
		6:                return DUR_W'($urandom);
		7:                return 32'h7FFF_FFFE + DUR_W'($urandom_range(0, 4));
		8:                return 32'hFFFF_FFFF - DUR_W'($urandom_range(0, 3));
		default:          return DUR_W'(1) << $urandom_range(0, 31);
		endcase
	endfunction

	initial begin
		int target;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(CMD_TICK, '0, '0);                 // nothing due, no word
		issue(CMD_CANCEL, '0, 4'd15);            // cancel of an idle slot
		issue(CMD_ONE, '0, '0);                  // due at once
		issue(CMD_REP, '0, '0);                  // zero period behaves as one-shot
		issue(CMD_ONE, 32'hFFFF_FFFF, '0);       // wraps to already due
		issue(CMD_REP, 32'h7FFF_FFFF, '0);       // far future, not due
		issue(CMD_ONE, 32'h8000_0000, '0);       // half range is not due
		issue(CMD_ONE, 32'd1, '0);
		issue(CMD_TICK, '0, 4'hA);
		issue(CMD_CANCEL, 32'hFFFF_FFFF, '0);
		// fill the table with repeaters that are due on every command, then overflow:
		// the last start and the overflow each fill the result cap, and each slot refires on later commands
		repeat (15) issue(CMD_REP, 32'hFFFF_FFFF, 4'hF);
		issue(CMD_ONE, 32'd5, '0);

		target = issued + RANDOM_ITEMS;
		while (issued < target) begin
			if (issued >= target - CALM_ITEMS)
				calm = 1'b1;
			case ($urandom_range(0, 9))
			0, 1, 2: repeat ($urandom_range(1, 6))
				issue($urandom_range(0, 1) ? CMD_REP : CMD_ONE, pick_duration(),
					SID_W'($urandom));
			3, 4, 5: repeat ($urandom_range(1, 10))
				issue(CMD_TICK, DUR_W'($urandom), SID_W'($urandom));
			6, 7: repeat ($urandom_range(1, 4))
				issue(CMD_CANCEL, DUR_W'($urandom), SID_W'($urandom));
			8: for (int s = 0; s < 16; s++)
				issue(CMD_CANCEL, DUR_W'($urandom), SID_W'(s));
			default: issue(CMD_W'($urandom), DUR_W'($urandom), SID_W'($urandom));
			endcase
		end
		req_valid <= 1'b0;

		do @(posedge clk); while (words_owed != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("ran %0d commands (directed, then random bursts of starts, ticks, cancels)",
			cmds_seen);
		$display("checked %0d result words, %0d of them timer fires", words_seen, fires_seen);
		if (mismatches == 0 && words_owed == 0)
			$display("PASS virtual_timer_multiplexer");
		else
			$display("FAIL virtual_timer_multiplexer");
		$finish;
	end

endmodule
